FILE: hw/rtl/ascii_to_unsigned_parser_defines.svh
// assertion macros shared by the parser rtl
// no dependencies; included by files that carry assertions
`ifndef ASCII_TO_UNSIGNED_PARSER_DEFINES_SVH
`define ASCII_TO_UNSIGNED_PARSER_DEFINES_SVH

// same-cycle implication, off while reset is high
`define ATUP_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("parser check failed");

// next-cycle implication, off while reset is high
`define ATUP_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("parser check failed");

`endif

FILE: hw/rtl/atup_pkg.sv
// shared types and constants for the string to unsigned parser
// no dependencies
package atup_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int INDEX_WIDTH = 12;
   localparam int BASE_WIDTH  = 6;
   localparam int CHAR_WIDTH  = 8;
   localparam int DIGIT_WIDTH = 6;

   // radix values
   localparam logic [BASE_WIDTH-1:0] RADIX_AUTO  = 6'd0;
   localparam logic [BASE_WIDTH-1:0] RADIX_UNARY = 6'd1;
   localparam logic [BASE_WIDTH-1:0] RADIX_BIN   = 6'd2;
   localparam logic [BASE_WIDTH-1:0] RADIX_OCT   = 6'd8;
   localparam logic [BASE_WIDTH-1:0] RADIX_DEC   = 6'd10;
   localparam logic [BASE_WIDTH-1:0] RADIX_HEX   = 6'd16;
   localparam logic [BASE_WIDTH-1:0] RADIX_MAX   = 6'd36;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [1:0] STATUS_BAD_BASE = 2'd2;

   // characters
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LF    = 8'h0a;
   localparam logic [CHAR_WIDTH-1:0] CHAR_VT    = 8'h0b;
   localparam logic [CHAR_WIDTH-1:0] CHAR_FF    = 8'h0c;
   localparam logic [CHAR_WIDTH-1:0] CHAR_CR    = 8'h0d;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2b;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UP_A  = 8'h41;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UP_B  = 8'h42;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UP_X  = 8'h58;
   localparam logic [CHAR_WIDTH-1:0] CHAR_UP_Z  = 8'h5a;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LO_A  = 8'h61;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LO_B  = 8'h62;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LO_X  = 8'h78;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LO_Z  = 8'h7a;
   localparam logic [CHAR_WIDTH-1:0] LETTER_BIAS = 8'd10;

   typedef struct packed {
      logic                   blank;
      logic                   plus;
      logic                   minus;
      logic                   zero;
      logic                   hex_mark;
      logic                   bin_mark;
      logic                   alnum;
      logic [DIGIT_WIDTH-1:0] digit;
   } char_class_type;

endpackage

FILE: hw/rtl/atup_char_class.sv
// character decoder: whitespace, sign, prefix letters and digit value
// depends on atup_pkg
module atup_char_class (
   input  logic [atup_pkg::CHAR_WIDTH-1:0] char_code,
   output atup_pkg::char_class_type        char_class
);
   import atup_pkg::*;

   logic                  is_num;
   logic                  is_lower;
   logic                  is_upper;
   logic [CHAR_WIDTH-1:0] offset;

   always_comb begin
      is_num   = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
      is_lower = (char_code >= CHAR_LO_A) && (char_code <= CHAR_LO_Z);
      is_upper = (char_code >= CHAR_UP_A) && (char_code <= CHAR_UP_Z);

      priority if (is_num) begin
         offset = char_code - CHAR_ZERO;
      end else if (is_lower) begin
         offset = char_code - CHAR_LO_A + LETTER_BIAS;
      end else if (is_upper) begin
         offset = char_code - CHAR_UP_A + LETTER_BIAS;
      end else begin
         offset = '0;
      end

      char_class.blank    = (char_code == CHAR_SPACE) || (char_code == CHAR_TAB) ||
                            (char_code == CHAR_LF) || (char_code == CHAR_CR) ||
                            (char_code == CHAR_VT) || (char_code == CHAR_FF);
      char_class.plus     = (char_code == CHAR_PLUS);
      char_class.minus    = (char_code == CHAR_MINUS);
      char_class.zero     = (char_code == CHAR_ZERO);
      char_class.hex_mark = (char_code == CHAR_LO_X) || (char_code == CHAR_UP_X);
      char_class.bin_mark = (char_code == CHAR_LO_B) || (char_code == CHAR_UP_B);
      char_class.alnum    = is_num || is_lower || is_upper;
      char_class.digit    = offset[DIGIT_WIDTH-1:0];
   end

endmodule

FILE: hw/rtl/ascii_to_unsigned_parser.sv
// top level of the streaming string to unsigned parser
// depends on atup_pkg, atup_char_class and ascii_to_unsigned_parser_defines.svh
//
// One character enters per request; a request with string_start begins a new
// string and samples the base register. Leading whitespace and one sign are
// skipped, an optional 0x / 0b / 0 prefix picks the radix, and digits are
// accumulated until the first non-digit, which produces one response with
// the value, the index of that character and a status. Characters after the
// end of a string are dropped without a response. The block takes one
// character per cycle while the response is not stalled: a request is held
// in the input register, then a combinational step (character decode, 64 by 6
// multiply and add with the overflow check) updates the running state and
// loads the response register, which drives the response outputs. A stalled
// response holds the response register and, once the input register is also
// full, stalls the request channel.
`include "ascii_to_unsigned_parser_defines.svh"

module ascii_to_unsigned_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [atup_pkg::BASE_WIDTH-1:0]   csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [atup_pkg::CHAR_WIDTH-1:0]   req_char_code,
   input  logic                              req_string_start,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [atup_pkg::VALUE_WIDTH-1:0]  rsp_parsed_value,
   output logic [atup_pkg::INDEX_WIDTH-1:0]  rsp_stop_index,
   output logic [1:0]                        rsp_parse_status
);
   import atup_pkg::*;

   localparam int PROD_WIDTH = VALUE_WIDTH + BASE_WIDTH;

   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_SPACE  = 3'd1;
   localparam logic [2:0] PH_PREFIX = 3'd2;
   localparam logic [2:0] PH_ZERO   = 3'd3;
   localparam logic [2:0] PH_DIGITS = 3'd4;

   logic [BASE_WIDTH-1:0]  csr_base_ff;

   logic                   s1_valid_ff;
   logic [CHAR_WIDTH-1:0]  s1_char_ff;
   logic                   s1_start_ff;

   logic [2:0]             phase_ff,  phase_in;
   logic [VALUE_WIDTH-1:0] acc_ff,    acc_in;
   logic                   ovf_ff,    ovf_in;
   logic                   minus_ff,  minus_in;
   logic [BASE_WIDTH-1:0]  base_ff,   base_in;
   logic [INDEX_WIDTH-1:0] count_ff,  count_in;

   logic                   rsp_valid_ff;
   logic [VALUE_WIDTH-1:0] rsp_value_ff;
   logic [INDEX_WIDTH-1:0] rsp_index_ff;
   logic [1:0]             rsp_status_ff;

   char_class_type         cls;

   logic                   out_free;
   logic                   step;

   logic [2:0]             cur_phase;
   logic [VALUE_WIDTH-1:0] cur_acc;
   logic                   cur_ovf;
   logic                   cur_minus;
   logic [BASE_WIDTH-1:0]  cur_base;
   logic [INDEX_WIDTH-1:0] cur_count;
   logic                   bad_base;
   logic                   do_digit;
   logic                   digit_ok;
   logic                   finish;
   logic                   emit;
   logic [PROD_WIDTH-1:0]  product;
   logic [VALUE_WIDTH-1:0] emit_value;
   logic [1:0]             emit_status;

   atup_char_class u_char_class (
      .char_code  (s1_char_ff),
      .char_class (cls)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;

   always_comb begin
      cur_phase = phase_ff;
      cur_acc   = acc_ff;
      cur_ovf   = ovf_ff;
      cur_minus = minus_ff;
      cur_base  = base_ff;
      cur_count = count_ff;
      bad_base  = 1'b0;

      // a start character reinitializes the string state
      if (s1_start_ff) begin
         cur_acc   = '0;
         cur_ovf   = 1'b0;
         cur_minus = 1'b0;
         cur_count = '0;
         cur_base  = csr_base_ff;
         if ((csr_base_ff == RADIX_UNARY) || (csr_base_ff > RADIX_MAX)) begin
            bad_base  = 1'b1;
            cur_phase = PH_IDLE;
         end else begin
            cur_phase = PH_SPACE;
         end
      end

      phase_in = cur_phase;
      acc_in   = cur_acc;
      ovf_in   = cur_ovf;
      minus_in = cur_minus;
      base_in  = cur_base;
      count_in = cur_count;
      do_digit = 1'b0;

      unique case (cur_phase)
         PH_SPACE: begin
            priority if (cls.blank) begin
               phase_in = PH_SPACE;
            end else if (cls.minus) begin
               minus_in = 1'b1;
               phase_in = PH_PREFIX;
            end else if (cls.plus) begin
               phase_in = PH_PREFIX;
            end else if (cls.zero) begin
               phase_in = PH_ZERO;
            end else begin
               if (cur_base == RADIX_AUTO) begin
                  base_in = RADIX_DEC;
               end
               do_digit = 1'b1;
            end
         end
         PH_PREFIX: begin
            if (cls.zero) begin
               phase_in = PH_ZERO;
            end else begin
               if (cur_base == RADIX_AUTO) begin
                  base_in = RADIX_DEC;
               end
               do_digit = 1'b1;
            end
         end
         PH_ZERO: begin
            priority if (cls.hex_mark &&
                         ((cur_base == RADIX_AUTO) || (cur_base == RADIX_HEX))) begin
               base_in  = RADIX_HEX;
               phase_in = PH_DIGITS;
            end else if (cls.bin_mark &&
                         ((cur_base == RADIX_AUTO) || (cur_base == RADIX_BIN))) begin
               base_in  = RADIX_BIN;
               phase_in = PH_DIGITS;
            end else begin
               // a lone leading zero means octal under autodetect
               if (cur_base == RADIX_AUTO) begin
                  base_in = RADIX_OCT;
               end
               do_digit = 1'b1;
            end
         end
         PH_DIGITS: begin
            do_digit = 1'b1;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      digit_ok = cls.alnum && (cls.digit < base_in);
      product  = PROD_WIDTH'(cur_acc) * PROD_WIDTH'(base_in) + PROD_WIDTH'(cls.digit);
      finish   = do_digit && !digit_ok;

      if (do_digit) begin
         if (digit_ok) begin
            acc_in   = product[VALUE_WIDTH-1:0];
            ovf_in   = cur_ovf || (|product[PROD_WIDTH-1:VALUE_WIDTH]);
            phase_in = PH_DIGITS;
         end else begin
            phase_in = PH_IDLE;
         end
      end

      emit = bad_base || finish;

      priority if (bad_base) begin
         emit_value  = '0;
         emit_status = STATUS_BAD_BASE;
      end else if (cur_ovf) begin
         emit_value  = '1;
         emit_status = STATUS_OVERFLOW;
      end else if (cur_minus) begin
         emit_value  = '0 - cur_acc;
         emit_status = STATUS_OK;
      end else begin
         emit_value  = cur_acc;
         emit_status = STATUS_OK;
      end

      // index counts every character taken in an open string that did not end it, saturating at all ones
      if ((cur_phase != PH_IDLE) && !finish && (cur_count != '1)) begin
         count_in = cur_count + INDEX_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_base_ff <= RADIX_AUTO;
      end else if (csr_write_enable) begin
         csr_base_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_char_ff  <= req_char_code;
         s1_start_ff <= req_string_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         ovf_ff   <= 1'b0;
         minus_ff <= 1'b0;
         base_ff  <= RADIX_AUTO;
         count_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         ovf_ff   <= ovf_in;
         minus_ff <= minus_in;
         base_ff  <= base_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= step && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_value_ff  <= emit_value;
         rsp_index_ff  <= cur_count;
         rsp_status_ff <= emit_status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parsed_value = rsp_value_ff;
   assign rsp_stop_index   = rsp_index_ff;
   assign rsp_parse_status = rsp_status_ff;

   `ATUP_ASSERT_NOW(a_stall_needs_full_output, clock, reset, req_stall, rsp_valid_ff)
   `ATUP_ASSERT_NOW(a_overflow_all_ones, clock, reset,
      rsp_valid_ff && (rsp_status_ff == STATUS_OVERFLOW), rsp_value_ff == '1)
   `ATUP_ASSERT_NOW(a_bad_base_zero, clock, reset,
      rsp_valid_ff && (rsp_status_ff == STATUS_BAD_BASE),
      (rsp_value_ff == '0) && (rsp_index_ff == '0))
   `ATUP_ASSERT_NEXT(a_overflow_sticky, clock, reset,
      ovf_ff && !(step && s1_start_ff), ovf_ff)
   `ATUP_ASSERT_NEXT(a_result_goes_idle, clock, reset, step && emit, phase_ff == PH_IDLE)

endmodule
